// ===== rtl/ggs_pkg.sv =====
// Package for the gripper grab sequencer.
// Holds the state codes, register indexes, reset values and shared structs.
// No dependencies.
package ggs_pkg;

    // configuration port geometry
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned TIME_W     = 32;

    // register reset values
    localparam logic [15:0] CLOSE_DELAY_RST      = 16'd20;
    localparam logic [15:0] PRESENT_DEBOUNCE_RST = 16'd20;
    localparam logic [15:0] ABSENT_DEBOUNCE_RST  = 16'd200;
    localparam logic [15:0] GRAB_COOLDOWN_RST    = 16'd0;
    localparam logic        AUTO_GRAB_RST        = 1'b0;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLOSE_DELAY      = 3'd0,
        REG_PRESENT_DEBOUNCE = 3'd1,
        REG_ABSENT_DEBOUNCE  = 3'd2,
        REG_GRAB_COOLDOWN    = 3'd3,
        REG_AUTO_GRAB        = 3'd4
    } ggs_reg_idx_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_WAIT = 2'd1,
        ST_HOLD = 2'd2
    } ggs_state_t;

    // switch level that means an object sits in the gripper
    localparam logic LEVEL_PRESENT = 1'b0;
    localparam logic LEVEL_ABSENT  = 1'b1;

    typedef struct packed {
        logic [15:0] clamp_settle_ms;
        logic [15:0] present_debounce_ms;
        logic [15:0] absent_debounce_ms;
        logic [15:0] regrab_gap_ms;
        logic        auto_grab_enable;
    } ggs_cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              switch_level;
    } ggs_tick_t;

    typedef struct packed {
        logic       clamp_close;
        logic       servo_upright;
        logic [1:0] fsm_state_out;
        logic       present_raw;
        logic       present_confirmed;
        logic       absent_confirmed;
    } ggs_result_t;

endpackage

// ===== rtl/ggs_tick_if.sv =====
// Input channel of the gripper grab sequencer: one control tick per beat.
// Carries valid, ready and the tick payload. No dependencies.
interface ggs_tick_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        switch_level;

    modport source (output valid, output now_ms, output switch_level, input ready);
    modport sink   (input valid, input now_ms, input switch_level, output ready);
endinterface

// ===== rtl/ggs_result_if.sv =====
// Output channel of the gripper grab sequencer: one result per beat.
// Carries valid, ready and the result payload. No dependencies.
interface ggs_result_if;
    logic       valid;
    logic       ready;
    logic       clamp_close;
    logic       servo_upright;
    logic [1:0] fsm_state_out;
    logic       present_raw;
    logic       present_confirmed;
    logic       absent_confirmed;

    modport source (
        output valid, output clamp_close, output servo_upright, output fsm_state_out,
        output present_raw, output present_confirmed, output absent_confirmed,
        input ready
    );
    modport sink (
        input valid, input clamp_close, input servo_upright, input fsm_state_out,
        input present_raw, input present_confirmed, input absent_confirmed,
        output ready
    );
endinterface

// ===== rtl/ggs_core.sv =====
// Tick logic of the gripper grab sequencer: level filter, debounce and
// grab state machine with their registers. Depends on ggs_pkg.
module ggs_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  ggs_pkg::ggs_tick_t  tick,
    input  ggs_pkg::ggs_cfg_t   cfg,
    output ggs_pkg::ggs_result_t res
);
    import ggs_pkg::*;

    ggs_state_t        state_reg, state_next;
    logic              held_level_reg, held_level_next;
    logic [TIME_W-1:0] level_since_ms_reg, level_since_ms_next;
    logic [TIME_W-1:0] close_start_ms_reg, close_start_ms_next;
    logic [TIME_W-1:0] last_grab_ms_reg, last_grab_ms_next;
    logic              clamp_reg, clamp_next;
    logic              servo_reg, servo_next;

    logic [TIME_W-1:0] held_age;
    logic [TIME_W-1:0] grab_age;
    logic [TIME_W-1:0] close_age;
    logic              present;
    logic              absent;
    logic              cooldown_ok;
    logic              delay_done;

    // level filter: restart the hold timer on any change of level
    always_comb
    begin
        if (tick.switch_level != held_level_reg)
        begin
            held_level_next     = tick.switch_level;
            level_since_ms_next = tick.now_ms;
        end
        else
        begin
            held_level_next     = held_level_reg;
            level_since_ms_next = level_since_ms_reg;
        end
    end

    // debounce and timer compares, all differences wrap
    assign held_age    = tick.now_ms - level_since_ms_next;
    assign grab_age    = tick.now_ms - last_grab_ms_reg;
    assign close_age   = tick.now_ms - close_start_ms_reg;
    assign present     = (held_level_next == LEVEL_PRESENT) &&
                         (held_age >= {16'd0, cfg.present_debounce_ms});
    assign absent      = (held_level_next == LEVEL_ABSENT) &&
                         (held_age >= {16'd0, cfg.absent_debounce_ms});
    assign cooldown_ok = grab_age >= {16'd0, cfg.regrab_gap_ms};
    assign delay_done  = close_age >= {16'd0, cfg.clamp_settle_ms};

    // grab sequence next state and drives
    always_comb
    begin
        state_next          = state_reg;
        close_start_ms_next = close_start_ms_reg;
        last_grab_ms_next   = last_grab_ms_reg;
        clamp_next          = clamp_reg;
        servo_next          = servo_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                servo_next = 1'b0;
                clamp_next = 1'b0;
                if (cfg.auto_grab_enable && present && cooldown_ok)
                begin
                    last_grab_ms_next   = tick.now_ms;
                    close_start_ms_next = tick.now_ms;
                    clamp_next          = 1'b1;
                    state_next          = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                clamp_next = 1'b1;
                if (absent)
                begin
                    clamp_next = 1'b0;
                    state_next = ST_IDLE;
                end
                else if (delay_done)
                begin
                    if (present)
                    begin
                        servo_next = 1'b1;
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        clamp_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_HOLD:
            begin
                servo_next = 1'b1;
                clamp_next = 1'b1;
                if (absent)
                begin
                    clamp_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                servo_next = 1'b0;
                clamp_next = 1'b0;
            end
        endcase
    end

    // sequencer registers, advanced once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            held_level_reg     <= LEVEL_ABSENT;
            level_since_ms_reg <= '0;
            close_start_ms_reg <= '0;
            last_grab_ms_reg   <= '0;
            clamp_reg          <= 1'b0;
            servo_reg          <= 1'b0;
        end
        else if (step)
        begin
            state_reg          <= state_next;
            held_level_reg     <= held_level_next;
            level_since_ms_reg <= level_since_ms_next;
            close_start_ms_reg <= close_start_ms_next;
            last_grab_ms_reg   <= last_grab_ms_next;
            clamp_reg          <= clamp_next;
            servo_reg          <= servo_next;
        end
    end

    // result of this tick
    always_comb
    begin
        res.clamp_close       = clamp_next;
        res.servo_upright     = servo_next;
        res.fsm_state_out     = state_next;
        res.present_raw       = (tick.switch_level == LEVEL_PRESENT);
        res.present_confirmed = present;
        res.absent_confirmed  = absent;
    end

endmodule

// ===== rtl/gripper_grab_sequencer.sv =====
// Gripper grab sequencer: one control tick in, one result beat out. Each
// tick beat carries a millisecond timestamp and the raw presence switch
// level (low = object present); the result gives clamp and servo drive,
// the sequencer state and the debounced presence and absence flags. The
// block takes one tick per clock cycle while the sink takes results: a tick
// is captured in the input register, runs through the filter and state
// machine when the output register is free and lands in it, which holds
// it until the sink takes it while the next tick is already captured. The
// configuration registers are written through cfg_we/cfg_index/cfg_data and
// should only change while no tick is in flight; indexes past the last
// register are ignored. Depends on ggs_pkg, ggs_tick_if, ggs_result_if and
// ggs_core.
module gripper_grab_sequencer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ggs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ggs_pkg::CFG_DATA_W-1:0]        cfg_data,
    ggs_tick_if.sink                              in_ch,
    ggs_result_if.source                          out_ch
);
    import ggs_pkg::*;

    ggs_cfg_t    cfg_reg;
    ggs_tick_t   in_data_reg;
    logic        in_valid_reg, in_valid_next;
    ggs_result_t out_data_reg;
    logic        out_valid_reg, out_valid_next;
    ggs_result_t core_res;

    logic in_beat;
    logic out_free;
    logic advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clamp_settle_ms     <= CLOSE_DELAY_RST;
            cfg_reg.present_debounce_ms <= PRESENT_DEBOUNCE_RST;
            cfg_reg.absent_debounce_ms  <= ABSENT_DEBOUNCE_RST;
            cfg_reg.regrab_gap_ms       <= GRAB_COOLDOWN_RST;
            cfg_reg.auto_grab_enable    <= AUTO_GRAB_RST;
        end
        else if (cfg_we)
        begin
            unique case (ggs_reg_idx_t'(cfg_index))
                REG_CLOSE_DELAY:      cfg_reg.clamp_settle_ms     <= cfg_data;
                REG_PRESENT_DEBOUNCE: cfg_reg.present_debounce_ms <= cfg_data;
                REG_ABSENT_DEBOUNCE:  cfg_reg.absent_debounce_ms  <= cfg_data;
                REG_GRAB_COOLDOWN:    cfg_reg.regrab_gap_ms       <= cfg_data;
                REG_AUTO_GRAB:        cfg_reg.auto_grab_enable    <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // pipeline handshake: the input stage moves when the output slot is free
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign advance      = in_valid_reg && out_free;
    assign in_ch.ready  = !in_valid_reg || out_free;
    assign in_beat      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_beat)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            in_data_reg.now_ms       <= in_ch.now_ms;
            in_data_reg.switch_level <= in_ch.switch_level;
        end
    end

    // tick logic and sequencer state
    ggs_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .tick  (in_data_reg),
        .cfg   (cfg_reg),
        .res   (core_res)
    );

    // output register
    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= core_res;
    end

    // result beat
    assign out_ch.valid             = out_valid_reg;
    assign out_ch.clamp_close       = out_data_reg.clamp_close;
    assign out_ch.servo_upright     = out_data_reg.servo_upright;
    assign out_ch.fsm_state_out     = out_data_reg.fsm_state_out;
    assign out_ch.present_raw       = out_data_reg.present_raw;
    assign out_ch.present_confirmed = out_data_reg.present_confirmed;
    assign out_ch.absent_confirmed  = out_data_reg.absent_confirmed;

endmodule

// ===== tb/ggs_checker.sv =====
// Result checker for the gripper grab sequencer testbench: watches the tick,
// result and config ports, predicts every result beat and compares it.
// Depends on ggs_pkg, ggs_tick_if and ggs_result_if.
module ggs_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ggs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ggs_pkg::CFG_DATA_W-1:0] cfg_data,
    ggs_tick_if                            tick_mon,
    ggs_result_if                          result_mon,
    output int                             failures,
    output int                             outstanding
);
    import ggs_pkg::*;

    // shadow of the configuration registers and of the sequencer state
    ggs_cfg_t          cfg_shadow;
    ggs_state_t        seq_state;
    logic              sw_level;
    logic [TIME_W-1:0] sw_since;
    logic [TIME_W-1:0] close_t0;
    logic [TIME_W-1:0] grab_t0;
    logic              clamp_on;
    logic              servo_up;

    ggs_result_t       expected_results[$];
    int                mismatch_count = 0;
    int                result_beats = 0;

    assign failures = mismatch_count;

    // true when the filtered level is lvl and has held for at least need ms
    function automatic logic held_for(input logic lvl, input logic [TIME_W-1:0] now,
                                      input logic [15:0] need);
        logic [TIME_W-1:0] span;
        span = now - sw_since;
        return (sw_level == lvl) && (span >= {16'd0, need});
    endfunction

    // advance the shadow state by one tick and return the result it yields
    function automatic ggs_result_t predict_tick(input logic [TIME_W-1:0] now,
                                                 input logic lvl);
        ggs_result_t       beat;
        logic              seen_present;
        logic              seen_absent;
        logic [TIME_W-1:0] since_grab;
        logic [TIME_W-1:0] since_close;

        // level filter first, confirmations taken after it
        if (lvl != sw_level)
        begin
            sw_level = lvl;
            sw_since = now;
        end
        seen_present = held_for(LEVEL_PRESENT, now, cfg_shadow.present_debounce_ms);
        seen_absent  = held_for(LEVEL_ABSENT, now, cfg_shadow.absent_debounce_ms);
        since_grab   = now - grab_t0;
        since_close  = now - close_t0;

        case (seq_state)
            ST_IDLE:
            begin
                servo_up = 1'b0;
                clamp_on = 1'b0;
                // grab only when enabled, confirmed and outside the cooldown
                if (cfg_shadow.auto_grab_enable && seen_present &&
                    since_grab >= {16'd0, cfg_shadow.regrab_gap_ms})
                begin
                    grab_t0   = now;
                    close_t0  = now;
                    clamp_on  = 1'b1;
                    seq_state = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                clamp_on = 1'b1;
                if (seen_absent)
                begin
                    clamp_on  = 1'b0;
                    seq_state = ST_IDLE;
                end
                else if (since_close >= {16'd0, cfg_shadow.clamp_settle_ms})
                begin
                    // after the close delay: lift if still held, else let go
                    if (seen_present)
                    begin
                        servo_up  = 1'b1;
                        seq_state = ST_HOLD;
                    end
                    else
                    begin
                        clamp_on  = 1'b0;
                        seq_state = ST_IDLE;
                    end
                end
            end
            ST_HOLD:
            begin
                servo_up = 1'b1;
                clamp_on = 1'b1;
                // servo stays upright on the tick that leaves hold
                if (seen_absent)
                begin
                    clamp_on  = 1'b0;
                    seq_state = ST_IDLE;
                end
            end
            default:
            begin
                servo_up  = 1'b0;
                clamp_on  = 1'b0;
                seq_state = ST_IDLE;
            end
        endcase

        beat.clamp_close       = clamp_on;
        beat.servo_upright     = servo_up;
        beat.fsm_state_out     = seq_state;
        beat.present_raw       = (lvl == LEVEL_PRESENT);
        beat.present_confirmed = seen_present;
        beat.absent_confirmed  = seen_absent;
        return beat;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("result beat %0d: %s is %0d, expected %0d", result_beats, what, got_v,
                 want_v);
        mismatch_count++;
    endtask

    // config capture, result compare, then prediction of accepted ticks
    always @(posedge clk or negedge rst_n)
    begin
        ggs_result_t got;
        ggs_result_t want;
        if (!rst_n)
        begin
            cfg_shadow = '{CLOSE_DELAY_RST, PRESENT_DEBOUNCE_RST, ABSENT_DEBOUNCE_RST,
                           GRAB_COOLDOWN_RST, AUTO_GRAB_RST};
            seq_state  = ST_IDLE;
            sw_level   = LEVEL_ABSENT;
            sw_since   = '0;
            close_t0   = '0;
            grab_t0    = '0;
            clamp_on   = 1'b0;
            servo_up   = 1'b0;
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // register writes, masked to the register width
            if (cfg_we)
            begin
                case (ggs_reg_idx_t'(cfg_index))
                    REG_CLOSE_DELAY:      cfg_shadow.clamp_settle_ms     = cfg_data;
                    REG_PRESENT_DEBOUNCE: cfg_shadow.present_debounce_ms = cfg_data;
                    REG_ABSENT_DEBOUNCE:  cfg_shadow.absent_debounce_ms  = cfg_data;
                    REG_GRAB_COOLDOWN:    cfg_shadow.regrab_gap_ms       = cfg_data;
                    REG_AUTO_GRAB:        cfg_shadow.auto_grab_enable    = cfg_data[0];
                    default: ;
                endcase
            end

            // result beat against the oldest expectation
            if (result_mon.valid && result_mon.ready)
            begin
                got = {result_mon.clamp_close, result_mon.servo_upright,
                       result_mon.fsm_state_out, result_mon.present_raw,
                       result_mon.present_confirmed, result_mon.absent_confirmed};
                if (expected_results.size() == 0)
                    report_mismatch("beat with nothing pending", 1, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.clamp_close !== want.clamp_close)
                        report_mismatch("clamp_close", got.clamp_close, want.clamp_close);
                    if (got.servo_upright !== want.servo_upright)
                        report_mismatch("servo_upright", got.servo_upright,
                                        want.servo_upright);
                    if (got.fsm_state_out !== want.fsm_state_out)
                        report_mismatch("fsm_state_out", got.fsm_state_out,
                                        want.fsm_state_out);
                    if (got.present_raw !== want.present_raw)
                        report_mismatch("present_raw", got.present_raw, want.present_raw);
                    if (got.present_confirmed !== want.present_confirmed)
                        report_mismatch("present_confirmed", got.present_confirmed,
                                        want.present_confirmed);
                    if (got.absent_confirmed !== want.absent_confirmed)
                        report_mismatch("absent_confirmed", got.absent_confirmed,
                                        want.absent_confirmed);
                end
                result_beats++;
            end

            if (tick_mon.valid && tick_mon.ready)
                expected_results.push_back(predict_tick(tick_mon.now_ms,
                                                        tick_mon.switch_level));
            outstanding <= expected_results.size();
        end
    end

endmodule

// ===== tb/tb_gripper_grab_sequencer.sv =====
// Testbench top for the gripper grab sequencer: drives tick beats, result
// back-pressure and config writes, and gives the verdict from ggs_checker.
// Depends on ggs_pkg, ggs_tick_if, ggs_result_if, ggs_checker and the block.
module tb_gripper_grab_sequencer;
    import ggs_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned NUM_PHASES    = 8;
    localparam int unsigned PHASE_TICKS   = 175;
    localparam int unsigned SETTLE_CYCLES = 4;
    // index past the last register, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    failures;
    int                    outstanding;
    int                    cycles = 0;
    int                    send_calm = 0;
    int                    take_calm = 0;
    int                    ticks_sent = 0;
    logic [TIME_W-1:0]     clock_ms;

    ggs_tick_if   tick_ch();
    ggs_result_if result_ch();

    gripper_grab_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (tick_ch),
        .out_ch    (result_ch)
    );

    ggs_checker watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .tick_mon    (tick_ch),
        .result_mon  (result_ch),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // idle cycles before the next beat, with occasional stretches of none
    function automatic int pick_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(8, 48);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    task automatic send_tick(input logic [TIME_W-1:0] stamp, input logic lvl);
        int gap;
        gap = pick_wait(send_calm);
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.now_ms       <= stamp;
        tick_ch.switch_level <= lvl;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
        ticks_sent++;
    endtask

    // tick a random number of ms after the previous one
    task automatic tick_at(input logic lvl, input int unsigned step);
        clock_ms = clock_ms + $urandom_range(0, step);
        send_tick(clock_ms, lvl);
    endtask

    // hold off ticks until every result beat is back
    task automatic wait_drained;
        tick_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    // write all registers, junk in the unused bits of the enable
    task automatic set_config(input ggs_cfg_t c);
        logic [CFG_DATA_W-1:0] junk;
        junk = 16'($urandom);
        cfg_put(REG_CLOSE_DELAY, c.clamp_settle_ms);
        cfg_put(REG_PRESENT_DEBOUNCE, c.present_debounce_ms);
        cfg_put(REG_ABSENT_DEBOUNCE, c.absent_debounce_ms);
        cfg_put(REG_GRAB_COOLDOWN, c.regrab_gap_ms);
        cfg_put(REG_AUTO_GRAB, {junk[15:1], c.auto_grab_enable});
        cfg_put(REG_SPARE, 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    // result side back-pressure
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = pick_wait(take_calm);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid) @(posedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        ggs_cfg_t    cfg;
        int unsigned longest;
        int unsigned step;
        int          target;

        rst_n = 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= '0;
        cfg_data             <= '0;
        tick_ch.valid        <= 1'b0;
        tick_ch.now_ms       <= '0;
        tick_ch.switch_level <= LEVEL_ABSENT;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, auto-grab off: debounce both ways, no grab
        send_tick(32'd0, LEVEL_ABSENT);
        send_tick(32'd5, LEVEL_PRESENT);
        send_tick(32'd25, LEVEL_PRESENT);
        send_tick(32'd300, LEVEL_ABSENT);
        send_tick(32'd500, LEVEL_ABSENT);

        // zero debounce, cooldown 50: grab, lift, release with servo still up,
        // grab refused inside the cooldown, release from the close wait
        wait_drained;
        set_config('{16'd10, 16'd0, 16'd0, 16'd50, 1'b1});
        send_tick(32'd1000, LEVEL_PRESENT);
        send_tick(32'd1005, LEVEL_PRESENT);
        send_tick(32'd1010, LEVEL_PRESENT);
        send_tick(32'd1011, LEVEL_ABSENT);
        send_tick(32'd1012, LEVEL_ABSENT);
        send_tick(32'd1020, LEVEL_PRESENT);
        send_tick(32'd1060, LEVEL_PRESENT);
        send_tick(32'd1062, LEVEL_ABSENT);
        send_tick(32'd1100, LEVEL_PRESENT);
        send_tick(32'd1110, LEVEL_PRESENT);

        // zero close delay, widest absent debounce, timestamps across the wrap:
        // reopen when the object is gone at the end of the close wait
        wait_drained;
        set_config('{16'd0, 16'd30, 16'hFFFF, 16'd0, 1'b1});
        send_tick(32'hFFFF_FFE0, LEVEL_ABSENT);
        send_tick(32'hFFFF_FFF0, LEVEL_PRESENT);
        send_tick(32'h0000_000E, LEVEL_PRESENT);
        send_tick(32'h0000_0010, LEVEL_ABSENT);
        send_tick(32'h0000_0020, LEVEL_PRESENT);
        send_tick(32'h0000_0040, LEVEL_PRESENT);
        send_tick(32'h0000_0041, LEVEL_PRESENT);
        send_tick(32'h0000_0050, LEVEL_ABSENT);
        send_tick(32'h0001_0050, LEVEL_ABSENT);
        send_tick(32'hFFFF_FFFF, LEVEL_ABSENT);

        // random phases, each under its own settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 0)
                cfg = '{16'd0, 16'd0, 16'd0, 16'd0, 1'b1};
            else if (p == 1)
                cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1};
            else if (p == NUM_PHASES - 1)
                cfg = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b1};
            else
                cfg = '{16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                        16'($urandom_range(0, 80)), 16'($urandom_range(0, 100)),
                        (p != 2)};

            // time steps scaled to the longest setting
            longest = cfg.clamp_settle_ms;
            if (cfg.present_debounce_ms > longest) longest = cfg.present_debounce_ms;
            if (cfg.absent_debounce_ms > longest) longest = cfg.absent_debounce_ms;
            if (cfg.regrab_gap_ms > longest) longest = cfg.regrab_gap_ms;
            step = longest / 3 + 2;
            if (p % 2 == 1)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * step);
            else
                clock_ms = $urandom;

            wait_drained;
            set_config(cfg);
            target = ticks_sent + PHASE_TICKS;
            while (ticks_sent < target)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    // contact bounce, object sits for a while, then taken away
                    repeat ($urandom_range(0, 3)) tick_at(1'($urandom_range(0, 1)), step);
                    repeat ($urandom_range(1, 14)) tick_at(LEVEL_PRESENT, step);
                    repeat ($urandom_range(1, 14)) tick_at(LEVEL_ABSENT, step);
                end
                else
                begin
                    // noise: arbitrary timestamps and levels
                    repeat ($urandom_range(1, 4))
                    begin
                        clock_ms = $urandom;
                        tick_at(1'($urandom_range(0, 1)), step);
                    end
                end
            end
        end

        wait_drained;
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ggs_pkg.sv
rtl/ggs_tick_if.sv
rtl/ggs_result_if.sv
rtl/ggs_core.sv
rtl/gripper_grab_sequencer.sv
tb/ggs_checker.sv
tb/tb_gripper_grab_sequencer.sv
